// File: rtl/core/lfmc_pkg.sv
// Shared constants, types and helpers of the line follower marker controller.
package lfmc_pkg;

    localparam int unsigned SPEED_W = 8;
    localparam int unsigned TICK_W  = 8;
    localparam int unsigned COUNT_W = 16;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 8'd150;

    localparam logic [TICK_W-1:0] START_WAIT_TICKS       = 8'd30;
    localparam logic [TICK_W-1:0] READ_HOLD_TICKS        = 8'd10;
    localparam logic [TICK_W-1:0] FIRST_RELEASE_TICKS    = 8'd35;
    localparam logic [TICK_W-1:0] GAP_TICKS              = 8'd35;
    localparam logic [TICK_W-1:0] JUNCTION_RELEASE_TICKS = 8'd70;
    localparam logic [TICK_W-1:0] SECOND_CONFIRM_TICKS   = 8'd1;
    localparam logic [TICK_W-1:0] BLINK_TICKS            = 8'd30;
    localparam logic [TICK_W-1:0] STOP_PAUSE_TICKS       = 8'd8;
    localparam logic [TICK_W-1:0] RUN_MAX                = 8'd255;

    // Stream layout: input tdata and output tdata widths.
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 24;

    typedef enum logic [2:0] {
        REG_CRUISE_SPEED     = 3'd0,
        REG_BOOST_SPEED      = 3'd1,
        REG_STEER_FAST_SPEED = 3'd2,
        REG_STEER_SLOW_SPEED = 3'd3,
        REG_CREEP_SPEED      = 3'd4,
        REG_BOOST_TICKS      = 3'd5,
        REG_CONFIRM_TICKS    = 3'd6,
        REG_BIAS_TICKS       = 3'd7
    } cfg_index_t;

    typedef enum logic [8:0] {
        PH_START  = 9'b000000001,
        PH_FOLLOW = 9'b000000010,
        PH_HOLD   = 9'b000000100,
        PH_PAUSE  = 9'b000001000,
        PH_REL1   = 9'b000010000,
        PH_GAP    = 9'b000100000,
        PH_JREL   = 9'b001000000,
        PH_BIAS   = 9'b010000000,
        PH_DONE   = 9'b100000000
    } phase_t;

    typedef enum logic {
        KIND_WHEELS = 1'b0,
        KIND_BLINK  = 1'b1
    } cmd_kind_t;

    function automatic logic [SPEED_W-1:0] sat_speed(input logic [SPEED_W-1:0] v);
        sat_speed = (v > SPEED_MAX) ? SPEED_MAX : v;
    endfunction

endpackage

// File: rtl/core/line_follow_marker_controller_core.sv
// Top level of the two-sensor line follower controller with marker handling.
//
// Usage: one beat on the s_ channel is one sensor sample tick. Each sample
// yields zero or one motor command on the m_ channel: a wheel speed pair or,
// after the finish, an end-blink command (m_tuser high). Speeds are the
// configured register values saturated at 150, or zero in stops and blinks.
// Configuration: cfg_we with cfg_addr and cfg_data writes one register in the
// same cycle; write only while no sample is in flight.
// Pipeline: a taken sample beat is held in the input register; its command
// is then held in the result register.
// Throughput: one sample per cycle while the result register is not stalled;
// the decision logic between the input register and the result register is a
// single pass of small counters and the phase register.
// Reset: the registers take their defaults, the phase is start wait. The first
// sample after reset gives a stop command and the next 29 are ignored.
// Stall: while the result register holds a beat that is not taken, one more
// sample waits in the input register, then s_tready drops; nothing is lost.
module line_follow_marker_controller_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // cfg
    input  logic                                cfg_we,
    input  logic [2:0]                          cfg_addr,
    input  logic [lfmc_pkg::SPEED_W-1:0]        cfg_data,
    // sample stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // bit 0 left_black, bit 1 right_black, bit 2 read_ok, rest zero
    input  logic [lfmc_pkg::IN_TDATA_W-1:0]     s_tdata,
    // command stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // bits 7:0 left_speed, 15:8 right_speed, bit 16 finished, rest zero
    output logic [lfmc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // bit 0 command_kind
    output logic                                m_tuser
);
    import lfmc_pkg::*;

    // Configuration registers.
    logic [SPEED_W-1:0] cruise_speed_reg, boost_speed_reg, steer_fast_reg, steer_slow_reg;
    logic [SPEED_W-1:0] creep_speed_reg;
    logic [TICK_W-1:0]  boost_ticks_reg, confirm_ticks_reg, bias_ticks_reg;

    // Input stage.
    logic in_valid_reg;
    logic in_lb_reg, in_rb_reg, in_ok_reg;

    // Controller state.
    phase_t               phase_reg, phase_next;
    logic [TICK_W-1:0]    phase_ticks_reg, phase_ticks_next;
    logic [TICK_W-1:0]    boost_count_reg, boost_count_next;
    logic [TICK_W-1:0]    black_run_reg, black_run_next;
    logic [COUNT_W-1:0]   marker_count_reg, marker_count_next;

    // Result register.
    logic                 out_valid_reg;
    logic                 out_kind_reg;
    logic [SPEED_W-1:0]   out_left_reg, out_right_reg;
    logic                 out_finished_reg;

    logic                 out_free, proc;
    logic                 emit;
    cmd_kind_t            emit_kind;
    logic [SPEED_W-1:0]   emit_left, emit_right;

    logic                 both;
    logic                 do_gap, do_bias;
    logic [TICK_W-1:0]    gap_run, gap_ticks, bias_base;
    logic [TICK_W:0]      ticks_inc;
    logic [TICK_W-1:0]    run_inc;
    logic [TICK_W-1:0]    need;

    assign out_free = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign both     = in_lb_reg && in_rb_reg;
    assign need     = (confirm_ticks_reg == '0) ? TICK_W'(1) : confirm_ticks_reg;

    always_comb
    begin
        phase_next        = phase_reg;
        phase_ticks_next  = phase_ticks_reg;
        boost_count_next  = boost_count_reg;
        black_run_next    = black_run_reg;
        marker_count_next = marker_count_reg;
        emit       = 1'b0;
        emit_kind  = KIND_WHEELS;
        emit_left  = '0;
        emit_right = '0;
        do_gap     = 1'b0;
        do_bias    = 1'b0;
        gap_run    = black_run_reg;
        gap_ticks  = phase_ticks_reg;
        bias_base  = phase_ticks_reg;
        ticks_inc  = {1'b0, phase_ticks_reg} + 9'd1;
        run_inc    = (black_run_reg < RUN_MAX) ? black_run_reg + 8'd1 : black_run_reg;

        unique case (phase_reg)
            PH_START:
            begin
                if (phase_ticks_reg == '0)
                begin
                    emit = 1'b1;
                end
                phase_ticks_next = ticks_inc[TICK_W-1:0];
                if (ticks_inc >= {1'b0, START_WAIT_TICKS})
                begin
                    phase_next       = PH_FOLLOW;
                    phase_ticks_next = '0;
                end
            end
            PH_FOLLOW:
            begin
                if (!in_ok_reg)
                begin
                    emit = 1'b1;
                    if (black_run_reg == '0)
                    begin
                        phase_next       = PH_HOLD;
                        phase_ticks_next = TICK_W'(1);
                    end
                    black_run_next = '0;
                end
                else if (both)
                begin
                    black_run_next = run_inc;
                    if (run_inc >= need)
                    begin
                        emit             = 1'b1;
                        black_run_next   = '0;
                        phase_ticks_next = '0;
                        phase_next       = (STOP_PAUSE_TICKS != '0) ? PH_PAUSE : PH_REL1;
                    end
                end
                else
                begin
                    black_run_next = '0;
                    emit           = 1'b1;
                    if (in_lb_reg)
                    begin
                        emit_left  = steer_slow_reg;
                        emit_right = steer_fast_reg;
                    end
                    else if (in_rb_reg)
                    begin
                        emit_left  = steer_fast_reg;
                        emit_right = steer_slow_reg;
                    end
                    else if (boost_count_reg < boost_ticks_reg)
                    begin
                        emit_left        = boost_speed_reg;
                        emit_right       = boost_speed_reg;
                        boost_count_next = boost_count_reg + 8'd1;
                    end
                    else
                    begin
                        emit_left  = cruise_speed_reg;
                        emit_right = cruise_speed_reg;
                    end
                end
            end
            PH_HOLD:
            begin
                phase_ticks_next = ticks_inc[TICK_W-1:0];
                if (ticks_inc >= {1'b0, READ_HOLD_TICKS})
                begin
                    phase_next       = PH_FOLLOW;
                    phase_ticks_next = '0;
                end
            end
            PH_PAUSE:
            begin
                phase_ticks_next = ticks_inc[TICK_W-1:0];
                if (ticks_inc >= {1'b0, STOP_PAUSE_TICKS})
                begin
                    phase_next       = PH_REL1;
                    phase_ticks_next = '0;
                end
            end
            PH_REL1:
            begin
                if (in_ok_reg && !both)
                begin
                    // The release sample also counts as the first gap tick.
                    phase_next = PH_GAP;
                    do_gap     = 1'b1;
                    gap_run    = '0;
                    gap_ticks  = '0;
                end
                else
                begin
                    emit             = 1'b1;
                    emit_left        = creep_speed_reg;
                    emit_right       = creep_speed_reg;
                    phase_ticks_next = ticks_inc[TICK_W-1:0];
                    if (ticks_inc >= {1'b0, FIRST_RELEASE_TICKS})
                    begin
                        marker_count_next = marker_count_reg + 16'd1;
                        phase_next        = PH_JREL;
                        phase_ticks_next  = '0;
                        black_run_next    = '0;
                    end
                end
            end
            PH_GAP:
            begin
                do_gap = 1'b1;
            end
            PH_JREL:
            begin
                if (in_ok_reg && !both)
                begin
                    do_bias   = 1'b1;
                    bias_base = '0;
                end
                else
                begin
                    emit             = 1'b1;
                    emit_left        = creep_speed_reg;
                    emit_right       = creep_speed_reg;
                    phase_ticks_next = ticks_inc[TICK_W-1:0];
                    if (ticks_inc >= {1'b0, JUNCTION_RELEASE_TICKS})
                    begin
                        phase_next       = PH_BIAS;
                        phase_ticks_next = '0;
                    end
                end
            end
            PH_BIAS:
            begin
                do_bias = 1'b1;
            end
            PH_DONE:
            begin
                if (phase_ticks_reg == '0)
                begin
                    emit      = 1'b1;
                    emit_kind = KIND_BLINK;
                end
                phase_ticks_next = ticks_inc[TICK_W-1:0];
                if (ticks_inc >= {1'b0, BLINK_TICKS})
                begin
                    phase_ticks_next = '0;
                end
            end
            default:
            begin
                phase_next       = PH_FOLLOW;
                phase_ticks_next = '0;
            end
        endcase

        if (do_gap)
        begin
            black_run_next = '0;
            if (in_ok_reg && both)
            begin
                black_run_next = (gap_run < RUN_MAX) ? gap_run + 8'd1 : gap_run;
            end
            emit = 1'b1;
            if (in_ok_reg && both && black_run_next >= SECOND_CONFIRM_TICKS)
            begin
                phase_next       = PH_DONE;
                phase_ticks_next = '0;
                black_run_next   = '0;
            end
            else
            begin
                emit_left        = creep_speed_reg;
                emit_right       = creep_speed_reg;
                phase_ticks_next = gap_ticks + 8'd1;
                if (({1'b0, gap_ticks} + 9'd1) >= {1'b0, GAP_TICKS})
                begin
                    marker_count_next = marker_count_reg + 16'd1;
                    phase_next        = PH_JREL;
                    phase_ticks_next  = '0;
                    black_run_next    = '0;
                end
            end
        end

        if (do_bias)
        begin
            emit = 1'b1;
            // Odd junction counts bias to the left, even ones to the right.
            if (marker_count_reg[0])
            begin
                emit_left  = steer_slow_reg;
                emit_right = steer_fast_reg;
            end
            else
            begin
                emit_left  = steer_fast_reg;
                emit_right = steer_slow_reg;
            end
            phase_next       = PH_BIAS;
            phase_ticks_next = bias_base + 8'd1;
            if (({1'b0, bias_base} + 9'd1) >= {1'b0, bias_ticks_reg})
            begin
                phase_next       = PH_FOLLOW;
                phase_ticks_next = '0;
                boost_count_next = '0;
                black_run_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cruise_speed_reg  <= 8'd125;
            boost_speed_reg   <= 8'd135;
            steer_fast_reg    <= 8'd145;
            steer_slow_reg    <= 8'd55;
            creep_speed_reg   <= 8'd80;
            boost_ticks_reg   <= 8'd25;
            confirm_ticks_reg <= 8'd5;
            bias_ticks_reg    <= 8'd26;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_addr))
                REG_CRUISE_SPEED:     cruise_speed_reg  <= cfg_data;
                REG_BOOST_SPEED:      boost_speed_reg   <= cfg_data;
                REG_STEER_FAST_SPEED: steer_fast_reg    <= cfg_data;
                REG_STEER_SLOW_SPEED: steer_slow_reg    <= cfg_data;
                REG_CREEP_SPEED:      creep_speed_reg   <= cfg_data;
                REG_BOOST_TICKS:      boost_ticks_reg   <= cfg_data;
                REG_CONFIRM_TICKS:    confirm_ticks_reg <= cfg_data;
                REG_BIAS_TICKS:       bias_ticks_reg    <= cfg_data;
                default:              cruise_speed_reg  <= cruise_speed_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            phase_reg        <= PH_START;
            phase_ticks_reg  <= '0;
            boost_count_reg  <= '0;
            black_run_reg    <= '0;
            marker_count_reg <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (proc)
            begin
                phase_reg        <= phase_next;
                phase_ticks_reg  <= phase_ticks_next;
                boost_count_reg  <= boost_count_next;
                black_run_reg    <= black_run_next;
                marker_count_reg <= marker_count_next;
            end
            if (proc && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_lb_reg <= s_tdata[0];
            in_rb_reg <= s_tdata[1];
            in_ok_reg <= s_tdata[2];
        end
        if (proc && emit)
        begin
            out_kind_reg     <= emit_kind;
            out_left_reg     <= (emit_kind == KIND_BLINK) ? '0 : sat_speed(emit_left);
            out_right_reg    <= (emit_kind == KIND_BLINK) ? '0 : sat_speed(emit_right);
            out_finished_reg <= (phase_next == PH_DONE);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {7'd0, out_finished_reg, out_right_reg, out_left_reg};

endmodule

// File: rtl/core/lfmc_checker.sv
// Port-level checker of the line follower controller and its bind.
module lfmc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [lfmc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                m_tuser
);
    import lfmc_pkg::*;

    logic done_seen_reg;

    // Remembers that a finish beat has been delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_seen_reg <= 1'b0;
        end
        else if (m_tvalid && m_tready && m_tdata[16])
        begin
            done_seen_reg <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled command beat changed");

    a_blink_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[16] && (m_tdata[15:0] == 16'd0))
        else $error("blink beat without finish flag or with speeds");

    a_speed_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:0] <= SPEED_MAX) && (m_tdata[15:8] <= SPEED_MAX))
        else $error("wheel speed above limit");

    a_finish_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && done_seen_reg |-> m_tdata[16] && m_tuser)
        else $error("command after finish is not a finished blink");

endmodule

bind line_follow_marker_controller_core lfmc_checker u_lfmc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/testbench.sv
// Self-checking testbench for the line follower marker controller core.
module testbench;
    import lfmc_pkg::*;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [7:0]       left_speed;
        logic [7:0]       right_speed;
        logic             finished;
    } motor_cmd_t;

    typedef struct packed {
        logic [7:0]       reps;
        logic [2:0]       smp;
        logic             typed;
        motor_cmd_t       want;
    } plan_row_t;

    // Sample codes, {read_ok, right_black, left_black}.
    localparam logic [2:0] SMP_FAIL       = 3'b000;
    localparam logic [2:0] SMP_FAIL_LEFT  = 3'b001;
    localparam logic [2:0] SMP_FAIL_BOTH  = 3'b011;
    localparam logic [2:0] SMP_FLOOR      = 3'b100;
    localparam logic [2:0] SMP_LEFT       = 3'b101;
    localparam logic [2:0] SMP_RIGHT      = 3'b110;
    localparam logic [2:0] SMP_BOTH       = 3'b111;

    localparam motor_cmd_t CMD_STOP    = '{KIND_WHEELS, 8'd0, 8'd0, 1'b0};
    localparam motor_cmd_t CMD_PREDICT = '0;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 300;

    // Rows with typed set carry their command; the rest are predicted.
    localparam plan_row_t DIRECTED_PLAN [16] = '{
        '{8'd1,  SMP_FLOOR,     1'b1, CMD_STOP},
        '{8'd29, SMP_BOTH,      1'b0, CMD_PREDICT},
        '{8'd1,  SMP_FLOOR,     1'b1, '{KIND_WHEELS, 8'd135, 8'd135, 1'b0}},
        '{8'd1,  SMP_LEFT,      1'b1, '{KIND_WHEELS, 8'd55, 8'd145, 1'b0}},
        '{8'd1,  SMP_RIGHT,     1'b1, '{KIND_WHEELS, 8'd145, 8'd55, 1'b0}},
        '{8'd1,  SMP_FAIL,      1'b1, CMD_STOP},
        '{8'd9,  SMP_BOTH,      1'b0, CMD_PREDICT},
        '{8'd2,  SMP_BOTH,      1'b0, CMD_PREDICT},
        '{8'd1,  SMP_FAIL_BOTH, 1'b1, CMD_STOP},
        '{8'd1,  SMP_FLOOR,     1'b0, CMD_PREDICT},
        '{8'd5,  SMP_BOTH,      1'b0, CMD_PREDICT},
        '{8'd8,  SMP_FLOOR,     1'b0, CMD_PREDICT},
        '{8'd1,  SMP_BOTH,      1'b0, CMD_PREDICT},
        '{8'd1,  SMP_FAIL_LEFT, 1'b0, CMD_PREDICT},
        '{8'd1,  SMP_RIGHT,     1'b0, CMD_PREDICT},
        '{8'd1,  SMP_LEFT,      1'b0, CMD_PREDICT}
    };

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [2:0]                 cfg_addr;
    logic [SPEED_W-1:0]         cfg_data;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [IN_TDATA_W-1:0]      s_tdata;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [OUT_TDATA_W-1:0]     m_tdata;
    logic                       m_tuser;

    // Predicted controller state and register copy.
    phase_t                     car_phase;
    logic [7:0]                 car_ticks;
    logic [7:0]                 car_boost;
    logic [7:0]                 car_black_run;
    logic [15:0]                car_markers;
    logic [7:0]                 car_regs [8];
    logic [7:0]                 next_regs [8];

    motor_cmd_t                 pending_cmds [$];
    int unsigned                error_count;
    int unsigned                cycle_count;
    int unsigned                counted_samples;
    int unsigned                gap_pct;
    int unsigned                stall_pct;
    int unsigned                hold_left;
    phase_t                     seen_phase;
    bit                         lingering;

    line_follow_marker_controller_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic motor_cmd_t wheels(input logic [7:0] l, input logic [7:0] r);
        motor_cmd_t c;
        c.kind        = KIND_WHEELS;
        c.left_speed  = (l > 8'd150) ? 8'd150 : l;
        c.right_speed = (r > 8'd150) ? 8'd150 : r;
        c.finished    = 1'b0;
        return c;
    endfunction

    task automatic enter_junction();
        car_markers   = car_markers + 16'd1;
        car_phase     = PH_JREL;
        car_ticks     = 8'd0;
        car_black_run = 8'd0;
    endtask

    task automatic bias_step(output motor_cmd_t c);
        if (car_markers[0])
            c = wheels(car_regs[REG_STEER_SLOW_SPEED], car_regs[REG_STEER_FAST_SPEED]);
        else
            c = wheels(car_regs[REG_STEER_FAST_SPEED], car_regs[REG_STEER_SLOW_SPEED]);
        car_ticks = car_ticks + 8'd1;
        if (car_ticks >= car_regs[REG_BIAS_TICKS])
        begin
            car_phase     = PH_FOLLOW;
            car_ticks     = 8'd0;
            car_boost     = 8'd0;
            car_black_run = 8'd0;
        end
    endtask

    task automatic gap_step(input logic ok, input logic both, output motor_cmd_t c);
        bit finish_now;
        finish_now = 1'b0;
        if (ok && both)
        begin
            if (car_black_run < RUN_MAX)
                car_black_run = car_black_run + 8'd1;
            finish_now = (car_black_run >= SECOND_CONFIRM_TICKS);
        end
        else
            car_black_run = 8'd0;
        if (finish_now)
        begin
            car_phase     = PH_DONE;
            car_ticks     = 8'd0;
            car_black_run = 8'd0;
            c = CMD_STOP;
        end
        else
        begin
            car_ticks = car_ticks + 8'd1;
            if (car_ticks >= GAP_TICKS)
                enter_junction();
            c = wheels(car_regs[REG_CREEP_SPEED], car_regs[REG_CREEP_SPEED]);
        end
    endtask

    // Advances the predicted controller by one sample tick.
    task automatic step_car(input logic [2:0] smp, output bit emitted, output motor_cmd_t c);
        logic       lb;
        logic       rb;
        logic       ok;
        logic       both;
        logic [7:0] need;
        lb = smp[0];
        rb = smp[1];
        ok = smp[2];
        both = lb & rb;
        emitted = 1'b0;
        c = CMD_STOP;
        case (car_phase)
            PH_START:
            begin
                emitted = (car_ticks == 8'd0);
                car_ticks = car_ticks + 8'd1;
                if (car_ticks >= START_WAIT_TICKS)
                begin
                    car_phase = PH_FOLLOW;
                    car_ticks = 8'd0;
                end
            end
            PH_FOLLOW:
            begin
                if (!ok)
                begin
                    emitted = 1'b1;
                    // A failure in the middle of a confirmation skips the hold.
                    if (car_black_run == 8'd0)
                    begin
                        car_phase = PH_HOLD;
                        car_ticks = 8'd1;
                    end
                    car_black_run = 8'd0;
                end
                else if (both)
                begin
                    need = (car_regs[REG_CONFIRM_TICKS] == 8'd0) ? 8'd1
                                                                 : car_regs[REG_CONFIRM_TICKS];
                    if (car_black_run < RUN_MAX)
                        car_black_run = car_black_run + 8'd1;
                    if (car_black_run >= need)
                    begin
                        emitted = 1'b1;
                        car_black_run = 8'd0;
                        car_ticks = 8'd0;
                        car_phase = (STOP_PAUSE_TICKS != 8'd0) ? PH_PAUSE : PH_REL1;
                    end
                end
                else
                begin
                    car_black_run = 8'd0;
                    emitted = 1'b1;
                    if (lb)
                        c = wheels(car_regs[REG_STEER_SLOW_SPEED], car_regs[REG_STEER_FAST_SPEED]);
                    else if (rb)
                        c = wheels(car_regs[REG_STEER_FAST_SPEED], car_regs[REG_STEER_SLOW_SPEED]);
                    else if (car_boost < car_regs[REG_BOOST_TICKS])
                    begin
                        c = wheels(car_regs[REG_BOOST_SPEED], car_regs[REG_BOOST_SPEED]);
                        car_boost = car_boost + 8'd1;
                    end
                    else
                        c = wheels(car_regs[REG_CRUISE_SPEED], car_regs[REG_CRUISE_SPEED]);
                end
            end
            PH_HOLD:
            begin
                car_ticks = car_ticks + 8'd1;
                if (car_ticks >= READ_HOLD_TICKS)
                begin
                    car_phase = PH_FOLLOW;
                    car_ticks = 8'd0;
                end
            end
            PH_PAUSE:
            begin
                car_ticks = car_ticks + 8'd1;
                if (car_ticks >= STOP_PAUSE_TICKS)
                begin
                    car_phase = PH_REL1;
                    car_ticks = 8'd0;
                end
            end
            PH_REL1:
            begin
                emitted = 1'b1;
                if (ok && !both)
                begin
                    car_phase = PH_GAP;
                    car_ticks = 8'd0;
                    car_black_run = 8'd0;
                    gap_step(ok, both, c);
                end
                else
                begin
                    c = wheels(car_regs[REG_CREEP_SPEED], car_regs[REG_CREEP_SPEED]);
                    car_ticks = car_ticks + 8'd1;
                    if (car_ticks >= FIRST_RELEASE_TICKS)
                        enter_junction();
                end
            end
            PH_GAP:
            begin
                emitted = 1'b1;
                gap_step(ok, both, c);
            end
            PH_JREL:
            begin
                emitted = 1'b1;
                if (ok && !both)
                begin
                    car_phase = PH_BIAS;
                    car_ticks = 8'd0;
                    bias_step(c);
                end
                else
                begin
                    c = wheels(car_regs[REG_CREEP_SPEED], car_regs[REG_CREEP_SPEED]);
                    car_ticks = car_ticks + 8'd1;
                    if (car_ticks >= JUNCTION_RELEASE_TICKS)
                    begin
                        car_phase = PH_BIAS;
                        car_ticks = 8'd0;
                    end
                end
            end
            PH_BIAS:
            begin
                emitted = 1'b1;
                bias_step(c);
            end
            PH_DONE:
            begin
                if (car_ticks == 8'd0)
                begin
                    emitted = 1'b1;
                    c.kind = KIND_BLINK;
                end
                car_ticks = car_ticks + 8'd1;
                if (car_ticks >= BLINK_TICKS)
                    car_ticks = 8'd0;
            end
            default:
            begin
                car_phase = PH_FOLLOW;
                car_ticks = 8'd0;
            end
        endcase
        c.finished = (car_phase == PH_DONE);
    endtask

    // Chooses the next sample from the predicted phase, so that markers run their
    // whole course; the finish is only allowed when asked for.
    function automatic logic [2:0] pick_sample(input bit finish_ok);
        int unsigned roll;
        logic [2:0]  smp;
        roll = $urandom_range(99);
        smp = 3'($urandom_range(7));
        if (car_phase != seen_phase)
            lingering = ($urandom_range(9) == 0);
        seen_phase = car_phase;
        case (car_phase)
            PH_FOLLOW:
            begin
                if (car_black_run != 8'd0)
                begin
                    if (roll < 95)
                        smp = SMP_BOTH;
                end
                else if (roll < 6)
                    smp = SMP_BOTH;
                else if (roll < 9)
                    smp[2] = 1'b0;
                else if (roll < 55)
                    smp = SMP_FLOOR;
                else if (roll < 78)
                    smp = SMP_LEFT;
                else
                    smp = SMP_RIGHT;
            end
            PH_REL1, PH_JREL:
            begin
                // A lingering marker keeps the sensors covered until the timeout.
                if (lingering || roll >= ((car_phase == PH_REL1) ? 60 : 15))
                begin
                    if (smp[2] && smp[1:0] != 2'b11)
                        smp = SMP_BOTH;
                end
                else
                begin
                    if (smp[1:0] == 2'b11)
                        smp[1:0] = 2'b00;
                    smp[2] = 1'b1;
                end
            end
            PH_GAP:
            begin
                if (finish_ok && roll < 30)
                    smp = SMP_BOTH;
                else if (smp == SMP_BOTH)
                    smp = SMP_FAIL_BOTH;
            end
            default:
            begin
            end
        endcase
        return smp;
    endfunction

    // Called just after a falling edge; returns just after the falling edge that follows the sample's acceptance.
    task automatic offer_sample(input logic [2:0] smp, input bit typed,
                                input motor_cmd_t typed_cmd);
        bit         emitted;
        motor_cmd_t cmd;
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-3){1'b0}}, smp};
        do
            @(posedge clk);
        while (!s_tready);
        counted_samples++;
        step_car(smp, emitted, cmd);
        if (typed)
            pending_cmds.push_back(typed_cmd);
        else if (emitted)
            pending_cmds.push_back(cmd);
        @(negedge clk);
    endtask

    task automatic drive_random(input int unsigned quota);
        int unsigned goal;
        goal = counted_samples + quota;
        while (counted_samples < goal)
            offer_sample(pick_sample(1'b0), 1'b0, CMD_PREDICT);
    endtask

    // Stops offering samples and lets every command drain before a register write.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic program_regs();
        for (int i = 0; i < 8; i++)
        begin
            cfg_we   <= 1'b1;
            cfg_addr <= 3'(i);
            cfg_data <= next_regs[i];
            car_regs[i] = next_regs[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        motor_cmd_t want;
        motor_cmd_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind        = cmd_kind_t'(m_tuser);
            got.left_speed  = m_tdata[7:0];
            got.right_speed = m_tdata[15:8];
            got.finished    = m_tdata[16];
            if (pending_cmds.size() == 0)
            begin
                $display("%0t: unexpected command beat %h, expected none", $time, got);
                error_count++;
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    if (got.kind !== want.kind)
                        $display("%0t: command_kind expected %0d got %0d",
                                 $time, want.kind, got.kind);
                    if (got.left_speed !== want.left_speed)
                        $display("%0t: left_speed expected %0d got %0d",
                                 $time, want.left_speed, got.left_speed);
                    if (got.right_speed !== want.right_speed)
                        $display("%0t: right_speed expected %0d got %0d",
                                 $time, want.right_speed, got.right_speed);
                    if (got.finished !== want.finished)
                        $display("%0t: finished expected %0d got %0d",
                                 $time, want.finished, got.finished);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        error_count = 0;
        cycle_count = 0;
        counted_samples = 0;
        gap_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        lingering = 1'b0;
        seen_phase = PH_START;
        car_phase = PH_START;
        car_ticks = 8'd0;
        car_boost = 8'd0;
        car_black_run = 8'd0;
        car_markers = 16'd0;
        car_regs[REG_CRUISE_SPEED]     = 8'd125;
        car_regs[REG_BOOST_SPEED]      = 8'd135;
        car_regs[REG_STEER_FAST_SPEED] = 8'd145;
        car_regs[REG_STEER_SLOW_SPEED] = 8'd55;
        car_regs[REG_CREEP_SPEED]      = 8'd80;
        car_regs[REG_BOOST_TICKS]      = 8'd25;
        car_regs[REG_CONFIRM_TICKS]    = 8'd5;
        car_regs[REG_BIAS_TICKS]       = 8'd26;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_PLAN[i])
            repeat (DIRECTED_PLAN[i].reps)
                offer_sample(DIRECTED_PLAN[i].smp, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
        drive_random(200);

        // Low extremes, saturating speeds, and zero confirm and bias counts.
        settle();
        next_regs[REG_CRUISE_SPEED]     = 8'd0;
        next_regs[REG_BOOST_SPEED]      = 8'd255;
        next_regs[REG_STEER_FAST_SPEED] = 8'd151;
        next_regs[REG_STEER_SLOW_SPEED] = 8'd0;
        next_regs[REG_CREEP_SPEED]      = 8'd150;
        next_regs[REG_BOOST_TICKS]      = 8'd0;
        next_regs[REG_CONFIRM_TICKS]    = 8'd0;
        next_regs[REG_BIAS_TICKS]       = 8'd0;
        program_regs();
        gap_pct = 49;
        stall_pct = 0;
        drive_random(250);

        settle();
        next_regs[REG_CRUISE_SPEED]     = 8'd150;
        next_regs[REG_BOOST_SPEED]      = 8'd1;
        next_regs[REG_STEER_FAST_SPEED] = 8'd255;
        next_regs[REG_STEER_SLOW_SPEED] = 8'd200;
        next_regs[REG_CREEP_SPEED]      = 8'd0;
        next_regs[REG_BOOST_TICKS]      = 8'd255;
        next_regs[REG_CONFIRM_TICKS]    = 8'd255;
        next_regs[REG_BIAS_TICKS]       = 8'd255;
        program_regs();
        gap_pct = 0;
        stall_pct = 49;
        drive_random(100);
        // The receiver holds off while samples keep coming, so the input stalls.
        hold_left = HOLD_CYCLES;
        drive_random(200);

        settle();
        for (int i = 0; i < 8; i++)
            next_regs[i] = 8'($urandom_range(255));
        next_regs[REG_CONFIRM_TICKS] = 8'($urandom_range(6, 1));
        next_regs[REG_BIAS_TICKS]    = 8'($urandom_range(30, 1));
        program_regs();
        gap_pct = 23;
        stall_pct = 23;
        drive_random(250);

        settle();
        for (int i = 0; i < 8; i++)
            next_regs[i] = 8'($urandom_range(255));
        next_regs[REG_BOOST_TICKS]   = 8'($urandom_range(40));
        next_regs[REG_CONFIRM_TICKS] = 8'($urandom_range(4));
        next_regs[REG_BIAS_TICKS]    = 8'($urandom_range(20));
        program_regs();
        gap_pct = 0;
        stall_pct = 0;
        drive_random(100);

        // The finish is final, so it comes last, followed by the blink period.
        while (car_phase != PH_DONE)
            offer_sample(pick_sample(1'b1), 1'b0, CMD_PREDICT);
        repeat (100)
            offer_sample(pick_sample(1'b1), 1'b0, CMD_PREDICT);

        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/lfmc_pkg.sv
rtl/core/line_follow_marker_controller_core.sv
rtl/core/lfmc_checker.sv
tb/testbench.sv
